// ----- rtl/signed_value_to_seven_segment_core_defines.svh -----
// Assertion helpers used by signed_value_to_seven_segment_core.sv.
`ifndef SIGNED_VALUE_TO_SEVEN_SEGMENT_CORE_DEFINES_SVH
`define SIGNED_VALUE_TO_SEVEN_SEGMENT_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SV7S_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sv7s same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SV7S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sv7s next-cycle check failed");

`endif

// ----- rtl/sv7s_pkg.sv -----
package sv7s_pkg;

   // Display geometry
   localparam int OUT_POSITIONS = 8;
   localparam int SEG_WIDTH     = 7;
   localparam int VALUE_WIDTH   = 32;

   typedef logic [SEG_WIDTH-1:0] sv7s_seg_type;

   // Segment patterns, bit 0 = a .. bit 6 = g
   localparam sv7s_seg_type SEG_BLANK = 7'h00;
   localparam sv7s_seg_type SEG_MINUS = 7'h40;

   // Per-item flags carried down the pipeline
   typedef struct packed {
      logic neg;
      logic over;
   } sv7s_flags_type;

   // Decimal digit to segment pattern; non-decimal codes are blank
   function automatic sv7s_seg_type seg_of(input logic [3:0] digit);
      sv7s_seg_type seg;
      unique case (digit)
         4'd0:    seg = 7'h3F;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5B;
         4'd3:    seg = 7'h4F;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6D;
         4'd6:    seg = 7'h7D;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h6F;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

// ----- rtl/sv7s_req_if.sv -----
interface sv7s_req_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [sv7s_pkg::VALUE_WIDTH-1:0]     value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/sv7s_rsp_if.sv -----
interface sv7s_rsp_if;
   logic                   valid;
   logic                   ready;
   sv7s_pkg::sv7s_seg_type digit0_segments;
   sv7s_pkg::sv7s_seg_type digit1_segments;
   sv7s_pkg::sv7s_seg_type digit2_segments;
   sv7s_pkg::sv7s_seg_type digit3_segments;
   sv7s_pkg::sv7s_seg_type digit4_segments;
   sv7s_pkg::sv7s_seg_type digit5_segments;
   sv7s_pkg::sv7s_seg_type digit6_segments;
   sv7s_pkg::sv7s_seg_type digit7_segments;
   logic                   overflow_error;

   modport source (
      output valid, input ready,
      output digit0_segments, output digit1_segments, output digit2_segments,
      output digit3_segments, output digit4_segments, output digit5_segments,
      output digit6_segments, output digit7_segments, output overflow_error
   );
   modport sink (
      input valid, output ready,
      input digit0_segments, input digit1_segments, input digit2_segments,
      input digit3_segments, input digit4_segments, input digit5_segments,
      input digit6_segments, input digit7_segments, input overflow_error
   );
endinterface

// ----- rtl/signed_value_to_seven_segment_core.sv -----
// Signed value to seven-segment display patterns.
//
// req_chan carries one signed 32-bit value per item; rsp_chan returns one
// item per request with eight segment patterns (digit0 rightmost, bit 0 =
// segment a) and overflow_error. Digits are right-aligned, a minus sits just
// left of the top digit, unused positions are blank and zero shows all 0s.
// A value needing more than DIGIT_COUNT positions sets overflow_error and
// shows the last magnitude that fitted, without a sign.
//
// The magnitude width W is clog2(10**DIGIT_COUNT), 27 bits at the default
// of 8. Throughput: one item per cycle while rsp_chan.ready is held high,
// set by a fully pipelined shift-and-add-3 converter doing up to four of
// its W bit steps per stage. Every stage has its own valid bit, so a
// stalled receiver only holds the stages that are full; an empty input
// stage keeps req_chan.ready high. Reset empties the pipeline and clears
// the kept magnitude to zero.
`include "signed_value_to_seven_segment_core_defines.svh"

module signed_value_to_seven_segment_core #(
   parameter int DIGIT_COUNT = 8
) (
   input logic         clock,
   input logic         reset,
   sv7s_req_if.sink    req_chan,
   sv7s_rsp_if.source  rsp_chan
);

   localparam int VW             = sv7s_pkg::VALUE_WIDTH;
   localparam int OutPos         = sv7s_pkg::OUT_POSITIONS;
   localparam int MagWidth       = $clog2(10 ** DIGIT_COUNT);
   localparam int StepsPerStage  = 4;
   localparam int StageCount     = (MagWidth + StepsPerStage - 1) / StepsPerStage;
   localparam int BcdWidth       = 4 * DIGIT_COUNT;
   localparam int PadDigits      = (DIGIT_COUNT > OutPos) ? DIGIT_COUNT : OutPos;
   localparam int PadWidth       = 4 * PadDigits;
   localparam logic [VW-1:0] LimitPlain = VW'(10 ** DIGIT_COUNT);
   localparam logic [VW-1:0] LimitNeg   = VW'(10 ** (DIGIT_COUNT - 1));

   // Input and magnitude stages
   logic [VW-1:0]       value_ff;
   logic                s0_valid_ff;
   logic                s0_ready;
   logic [VW-1:0]       mag_ff;
   logic [VW-1:0]       mag_in;
   logic                neg_ff;
   logic                s1_valid_ff;
   logic                s1_ready;

   // Kept magnitude and overflow decision
   logic [MagWidth-1:0] shown_ff;
   logic                over;
   logic                shown_load;

   // Converter pipeline links; index k feeds stage k
   logic [StageCount:0]       stg_valid;
   logic [StageCount:0]       stg_ready;
   logic [BcdWidth-1:0]       stg_bcd   [StageCount+1];
   logic [MagWidth-1:0]       stg_bin   [StageCount+1];
   sv7s_pkg::sv7s_flags_type  stg_flags [StageCount+1];

   // Rendering and result register
   logic [PadWidth-1:0]       digits_pad;
   logic [3:0]                dig     [PadDigits];
   logic [PadDigits-1:0]      nz_above;
   logic [PadDigits-1:0]      nz_prev;
   logic                      nz_run;
   sv7s_pkg::sv7s_seg_type    seg_in  [OutPos];
   sv7s_pkg::sv7s_seg_type    seg_ff  [OutPos];
   logic                      over_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_load_ready;
   logic                      minus_seen;
   logic                      digits_ok;

   // Input register
   assign s0_ready       = !s0_valid_ff || s1_ready;
   assign req_chan.ready = s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && s0_ready) begin
         value_ff <= $unsigned(req_chan.value);
      end
   end

   // Magnitude of the two's complement value
   assign mag_in   = value_ff[VW-1] ? (VW'(0) - value_ff) : value_ff;
   assign s1_ready = !s1_valid_ff || stg_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (s0_valid_ff && s1_ready) begin
         mag_ff <= mag_in;
         neg_ff <= value_ff[VW-1];
      end
   end

   // Overflow check; a minus takes one position
   assign over       = neg_ff ? (mag_ff >= LimitNeg) : (mag_ff >= LimitPlain);
   assign shown_load = s1_valid_ff && stg_ready[0] && !over;

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_ff <= '0;
      end else if (shown_load) begin
         shown_ff <= mag_ff[MagWidth-1:0];
      end
   end

   assign stg_valid[0]      = s1_valid_ff;
   assign stg_bcd[0]        = '0;
   assign stg_bin[0]        = over ? shown_ff : mag_ff[MagWidth-1:0];
   assign stg_flags[0].neg  = neg_ff && !over;
   assign stg_flags[0].over = over;

   // Binary to BCD pipeline
   for (genvar k = 0; k < StageCount; k++) begin : g_stage
      localparam int Steps = (k == StageCount - 1) ?
                             (MagWidth - StepsPerStage * (StageCount - 1)) : StepsPerStage;
      sv7s_dabble_stage #(
         .DIGITS     (DIGIT_COUNT),
         .BIN_WIDTH  (MagWidth),
         .STEP_COUNT (Steps)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_bcd    (stg_bcd[k]),
         .in_bin    (stg_bin[k]),
         .in_flags  (stg_flags[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_bcd   (stg_bcd[k+1]),
         .out_bin   (stg_bin[k+1]),
         .out_flags (stg_flags[k+1])
      );
   end

   // Digit positions: nz_above marks positions at or below the top digit
   assign digits_pad = PadWidth'(stg_bcd[StageCount]);
   assign nz_prev    = {nz_above[PadDigits-2:0], 1'b0};

   always_comb begin
      nz_run = 1'b0;
      for (int i = PadDigits - 1; i >= 0; i--) begin
         dig[i]      = digits_pad[4*i +: 4];
         nz_run      = nz_run || (dig[i] != 4'd0);
         nz_above[i] = nz_run;
      end
   end

   // Segment patterns per position
   always_comb begin
      for (int i = 0; i < OutPos; i++) begin
         seg_in[i] = sv7s_pkg::SEG_BLANK;
         if (i < DIGIT_COUNT) begin
            if (!nz_above[0]) begin
               seg_in[i] = sv7s_pkg::seg_of(4'd0);
            end else if (nz_above[i]) begin
               seg_in[i] = sv7s_pkg::seg_of(dig[i]);
            end else if (stg_flags[StageCount].neg && nz_prev[i]) begin
               seg_in[i] = sv7s_pkg::SEG_MINUS;
            end
         end
      end
   end

   // Result register
   assign rsp_load_ready        = !rsp_valid_ff || rsp_chan.ready;
   assign stg_ready[StageCount] = rsp_load_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load_ready) begin
         rsp_valid_ff <= stg_valid[StageCount];
      end
      if (stg_valid[StageCount] && rsp_load_ready) begin
         seg_ff  <= seg_in;
         over_ff <= stg_flags[StageCount].over;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.digit0_segments = seg_ff[0];
   assign rsp_chan.digit1_segments = seg_ff[1];
   assign rsp_chan.digit2_segments = seg_ff[2];
   assign rsp_chan.digit3_segments = seg_ff[3];
   assign rsp_chan.digit4_segments = seg_ff[4];
   assign rsp_chan.digit5_segments = seg_ff[5];
   assign rsp_chan.digit6_segments = seg_ff[6];
   assign rsp_chan.digit7_segments = seg_ff[7];
   assign rsp_chan.overflow_error  = over_ff;

   // Check helpers
   always_comb begin
      minus_seen = 1'b0;
      for (int i = 0; i < OutPos; i++) begin
         minus_seen = minus_seen || (seg_ff[i] == sv7s_pkg::SEG_MINUS);
      end
      digits_ok = 1'b1;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         digits_ok = digits_ok && (stg_bcd[StageCount][4*d +: 4] <= 4'd9);
      end
   end

   `SV7S_ASSERT_NOW(a_shown_fits, clock, reset, 1'b1, VW'(shown_ff) < LimitPlain)
   `SV7S_ASSERT_NEXT(a_shown_held, clock, reset, !shown_load, $stable(shown_ff))
   `SV7S_ASSERT_NOW(a_over_unsigned, clock, reset, rsp_valid_ff && over_ff, !minus_seen)
   `SV7S_ASSERT_NOW(a_bcd_decimal, clock, reset, stg_valid[StageCount], digits_ok)

endmodule

// ----- rtl/sv7s_dabble_stage.sv -----
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
// The stage registers its input and applies STEP_COUNT steps on the way out.
module sv7s_dabble_stage #(
   parameter int DIGITS     = 8,
   parameter int BIN_WIDTH  = 27,
   parameter int STEP_COUNT = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [4*DIGITS-1:0]      in_bcd,
   input  logic [BIN_WIDTH-1:0]     in_bin,
   input  sv7s_pkg::sv7s_flags_type in_flags,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [4*DIGITS-1:0]      out_bcd,
   output logic [BIN_WIDTH-1:0]     out_bin,
   output sv7s_pkg::sv7s_flags_type out_flags
);

   localparam int BcdWidth  = 4 * DIGITS;
   localparam int WorkWidth = BcdWidth + BIN_WIDTH;

   logic                     valid_ff;
   logic [BcdWidth-1:0]      bcd_ff;
   logic [BIN_WIDTH-1:0]     bin_ff;
   sv7s_pkg::sv7s_flags_type flags_ff;
   logic [WorkWidth-1:0]     work;

   // Stage holds when full and downstream is stalled
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         bcd_ff   <= in_bcd;
         bin_ff   <= in_bin;
         flags_ff <= in_flags;
      end
   end

   // Adjust each nibble of 5 or more by 3, then shift one bit in
   always_comb begin
      work = {bcd_ff, bin_ff};
      for (int s = 0; s < STEP_COUNT; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (work[BIN_WIDTH + 4*d +: 4] >= 4'd5) begin
               work[BIN_WIDTH + 4*d +: 4] = work[BIN_WIDTH + 4*d +: 4] + 4'd3;
            end
         end
         work = work << 1;
      end
   end

   assign out_valid = valid_ff;
   assign out_bcd   = work[WorkWidth-1 -: BcdWidth];
   assign out_bin   = work[BIN_WIDTH-1:0];
   assign out_flags = flags_ff;

endmodule
